// ----- rtl/psfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfc_pkg
// Types and constants shared by the phase-shifted Fourier correlation block.
// ----------------------------------------------------------------------------
package psfc_pkg;

  localparam int BOX_W     = 13;
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 32;
  localparam int DIV_CNT_W = 7;

  localparam logic [BOX_W-1:0] BOX_RESET = 13'd256;

  // Fixed-point constants of the sine polynomial (Q1.30, with a rounding constant for the shift by 15).
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] Q30_ONE     = 31'd1073741824;
  localparam logic [14:0] ROUND_Q15   = 15'd16384;

  // Reciprocals of the Taylor denominators 42, 20 and 6, scaled by 2^38.
  // The product shifted right by 38 is the exact quotient of any 32-bit numerator.
  localparam int          RECIP_SHIFT = 38;
  localparam logic [35:0] RECIP_42    = 36'd6544712071;
  localparam logic [35:0] RECIP_20    = 36'd13743895348;
  localparam logic [35:0] RECIP_6     = 36'd45812984491;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_EMIT
  } psfc_state_t;

  typedef enum logic [5:0] {
    OP_NONE,
    OP_PH_M1, OP_PH_M2, OP_PH_SUM,
    OP_MOD_GO, OP_MOD_FIX, OP_IDX_GO, OP_IDX_SET,
    OP_SQ_SEL, OP_SQ_M0, OP_SQ_XQ, OP_SQ_M2, OP_SQ_X2,
    OP_SQ_D1, OP_SQ_T1, OP_SQ_M3, OP_SQ_D2, OP_SQ_T2,
    OP_SQ_M4, OP_SQ_D3, OP_SQ_T3, OP_SQ_M5, OP_SQ_FIN,
    OP_R_M1, OP_R_M2, OP_R_M3, OP_R_Z,
    OP_T_M1, OP_T_M2, OP_T_M3, OP_T_M4, OP_T_ACC
  } psfc_op_t;

  typedef enum logic [1:0] {
    TERM_CROSS,
    TERM_OBS,
    TERM_PRED
  } psfc_term_t;

  typedef struct packed {
    psfc_op_t   op;
    logic       load;
    logic       div_start;
    logic       emit;
    logic       which;
    psfc_term_t sel;
  } psfc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic last;
  } psfc_stat_t;

  typedef struct packed {
    logic [11:0]        freq_x;
    logic [11:0]        freq_y;
    logic signed [23:0] shift_x;
    logic signed [23:0] shift_y;
    logic signed [23:0] obs_real;
    logic signed [23:0] obs_imag;
    logic signed [23:0] pred_real;
    logic signed [23:0] pred_imag;
    logic [15:0]        damage_weight;
    logic               last_item;
  } psfc_item_t;

  typedef struct packed {
    logic signed [63:0] cross_sum;
    logic [62:0]        obs_energy;
    logic [62:0]        pred_energy;
  } psfc_result_t;

endpackage
`default_nettype wire

// ----- rtl/psfc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfc channel interfaces
// Valid/ready channels for Fourier pixels in and correlation sums out.
// ----------------------------------------------------------------------------
interface psfc_in_if;
  logic               valid;
  logic               ready;
  logic [11:0]        freq_x;
  logic [11:0]        freq_y;
  logic signed [23:0] shift_x;
  logic signed [23:0] shift_y;
  logic signed [23:0] obs_real;
  logic signed [23:0] obs_imag;
  logic signed [23:0] pred_real;
  logic signed [23:0] pred_imag;
  logic [15:0]        damage_weight;
  logic               last_item;

  modport source (output valid, freq_x, freq_y, shift_x, shift_y, obs_real, obs_imag,
                  pred_real, pred_imag, damage_weight, last_item, input ready);
  modport sink (input valid, freq_x, freq_y, shift_x, shift_y, obs_real, obs_imag,
                pred_real, pred_imag, damage_weight, last_item, output ready);
endinterface

interface psfc_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] cross_sum;
  logic [62:0]        obs_energy;
  logic [62:0]        pred_energy;

  modport source (output valid, cross_sum, obs_energy, pred_energy, input ready);
  modport sink (input valid, cross_sum, obs_energy, pred_energy, output ready);
endinterface
`default_nettype wire

// ----- rtl/phase_shifted_fourier_correlation.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phase_shifted_fourier_correlation
// Shift-rotated correlation and energy sums over a set of Fourier pixels.
// ----------------------------------------------------------------------------
// Each pixel runs the whole step sequence from its transfer before the next
// pixel can be taken, and the pixel marked last passes the emit state too.
// The sequence holds two passes through the shared divider (phase modulo
// and phase index) and multiply and update steps, the Taylor denominators
// being handled by reciprocal multiplication. The sums come out in one
// result on the pixel marked last; that result sits in an output
// register, so the next pixel is taken while it waits, and only a second
// last pixel stalls until the first result has been transferred.
module phase_shifted_fourier_correlation #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int PHASE_BITS   = 16,
  parameter int ACC_WIDTH    = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  psfc_in_if.sink                     in_ch,
  psfc_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [psfc_pkg::BOX_W-1:0]  cfg_wdata
);
  import psfc_pkg::*;

  psfc_item_t   item;
  psfc_cmd_t    cmd;
  psfc_stat_t   stat;
  psfc_result_t res;
  logic         in_ready;
  logic         out_valid;

  assign item.freq_x        = in_ch.freq_x;
  assign item.freq_y        = in_ch.freq_y;
  assign item.shift_x       = in_ch.shift_x;
  assign item.shift_y       = in_ch.shift_y;
  assign item.obs_real      = in_ch.obs_real;
  assign item.obs_imag      = in_ch.obs_imag;
  assign item.pred_real     = in_ch.pred_real;
  assign item.pred_imag     = in_ch.pred_imag;
  assign item.damage_weight = in_ch.damage_weight;
  assign item.last_item     = in_ch.last_item;

  psfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  psfc_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .PHASE_BITS   (PHASE_BITS),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .res       (res)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.cross_sum   = res.cross_sum;
  assign out_ch.obs_energy  = res.obs_energy;
  assign out_ch.pred_energy = res.pred_energy;

  // A new result is loaded only when the output register is free or draining.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result loaded over an untaken result");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (cmd.op == OP_PH_M1))
    else $error("pixel transfer did not start the phase sequence");

endmodule
`default_nettype wire

// ----- rtl/psfc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfc_div
// Shared radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psfc_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [psfc_pkg::DIV_NUM_W-1:0]   dividend,
  input  logic [psfc_pkg::DIV_DEN_W-1:0]   divisor,
  output logic                             busy,
  output logic [psfc_pkg::DIV_NUM_W-1:0]   quotient,
  output logic [psfc_pkg::DIV_DEN_W-1:0]   remainder
);
  import psfc_pkg::*;

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] quo_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W:0]   trial;
  logic [DIV_DEN_W:0]   diff;

  assign trial = {rem_r, quo_r[DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(DIV_NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // The dividend shifts out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      if (!diff[DIV_DEN_W]) begin
        rem_r <= diff[DIV_DEN_W-1:0];
        quo_r <= {quo_r[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[DIV_DEN_W-1:0];
        quo_r <= {quo_r[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// ----- rtl/psfc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfc_dp
// Datapath: phase, sine/cosine, rotation, weighted terms and saturating sums.
// ----------------------------------------------------------------------------
module psfc_dp #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int PHASE_BITS   = 16,
  parameter int ACC_WIDTH    = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [psfc_pkg::BOX_W-1:0]   cfg_wdata,
  input  psfc_pkg::psfc_item_t         item,
  input  psfc_pkg::psfc_cmd_t          cmd,
  output psfc_pkg::psfc_stat_t         stat,
  output psfc_pkg::psfc_result_t       res
);
  import psfc_pkg::*;

  localparam int SW_EFF = (SAMPLE_WIDTH < 24) ? SAMPLE_WIDTH : 24;
  localparam int PB     = PHASE_BITS;
  localparam int AW     = ACC_WIDTH;
  localparam int MUL_W  = 38;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam logic [PB-1:0] QUARTER     = PB'(1) << (PB - 2);
  localparam logic [PB-2:0] QUARTER_ARG = (PB-1)'(1) << (PB - 2);
  localparam logic signed [SUM_W-1:0] ACC_HI =
    {{(SUM_W-AW+1){1'b0}}, {(AW-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_LO = ~ACC_HI;

  function automatic logic signed [23:0] samp(input logic [23:0] v);
    return 24'(signed'(v[SW_EFF-1:0]));
  endfunction

  function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] acc,
                                                   input logic signed [PROD_W-1:0] p,
                                                   input logic nonneg);
    logic signed [SUM_W-1:0] s;
    logic signed [SUM_W-1:0] lo;
    s  = SUM_W'(acc) + SUM_W'(p);
    lo = nonneg ? '0 : ACC_LO;
    if (s > ACC_HI) return ACC_HI[AW-1:0];
    if (s < lo) return lo[AW-1:0];
    return s[AW-1:0];
  endfunction

  logic [BOX_W-1:0]          box_r;
  logic [11:0]               x_r;
  logic signed [13:0]        yw_r;
  logic signed [23:0]        sx_r, sy_r, c_r, d_r, pr_r, pi_r;
  logic [15:0]               dmg_r;
  logic                      last_r;
  logic signed [PROD_W-1:0]  p_r;
  logic signed [38:0]        ph_r;
  logic [24:0]               r_r;
  logic [PB-1:0]             idx_r;
  logic [PB-2:0]             arg_r;
  logic                      neg_r;
  logic [30:0]               xq_r;
  logic [31:0]               x2_r;
  logic [30:0]               tt_r;
  logic signed [16:0]        sin_r, cos_r;
  logic signed [40:0]        ac_r, bd_r;
  logic signed [25:0]        zr_r, zi_r;
  logic signed [53:0]        sum_r;
  logic signed [MUL_W-1:0]   term_r;
  logic signed [AW-1:0]      cross_acc_r, obs_acc_r, pred_acc_r;
  psfc_result_t              res_r;

  logic [BOX_W-1:0]          s_eff;
  logic [BOX_W-1:0]          half_row;
  logic signed [13:0]        y_wrap;
  logic [24:0]               den;
  logic signed [38:0]        ph_abs;
  logic                      mul_en;
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [MUL_W-1:0]   t1a, t1b, t2a, t2b;
  logic signed [PROD_W-1:0]  prod;
  logic [DIV_NUM_W-1:0]      div_num;
  logic [DIV_DEN_W-1:0]      div_den;
  logic                      div_busy;
  logic [DIV_NUM_W-1:0]      div_quo;
  logic [DIV_DEN_W-1:0]      div_rem;
  logic [PB-1:0]             ang;
  logic [32:0]               s_round;
  logic [15:0]               s_mag;
  logic signed [16:0]        s_val;
  logic signed [42:0]        zr_full;
  logic signed [44:0]        zi_full;
  logic signed [53:0]        tsum;
  logic [63:0]               obs64, pred64;

  assign s_eff    = (box_r < BOX_W'(2)) ? BOX_W'(2) : box_r;
  assign half_row = BOX_W'(s_eff >> 1) + BOX_W'(1);
  assign y_wrap   = ({1'b0, item.freq_y} >= half_row)
                    ? $signed({2'b00, item.freq_y}) - $signed({1'b0, s_eff})
                    : $signed({2'b00, item.freq_y});
  assign den      = {s_eff, 12'd0};
  assign ph_abs   = ph_r[38] ? -ph_r : ph_r;

  assign ang     = cmd.which ? idx_r + QUARTER : idx_r;
  assign s_round = ({1'b0, p_r[61:30]} + 33'(ROUND_Q15)) >> 15;
  assign s_mag   = (s_round > 33'd32767) ? 16'd32767 : s_round[15:0];
  assign s_val   = neg_r ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

  assign zr_full = 43'(ac_r) - 43'(bd_r) + 43'(ROUND_Q15);
  assign zi_full = 45'(p_r) - 45'(ac_r) - 45'(bd_r) + 45'(ROUND_Q15);
  assign tsum    = sum_r + 54'(p_r);

  // Operand pairs of the two products that make up each weighted term.
  always_comb begin
    case (cmd.sel)
      TERM_CROSS: begin
        t1a = MUL_W'(pr_r); t1b = MUL_W'(zr_r);
        t2a = MUL_W'(pi_r); t2b = MUL_W'(zi_r);
      end
      TERM_OBS: begin
        t1a = MUL_W'(zr_r); t1b = MUL_W'(zr_r);
        t2a = MUL_W'(zi_r); t2b = MUL_W'(zi_r);
      end
      default: begin
        t1a = MUL_W'(pr_r); t1b = MUL_W'(pr_r);
        t2a = MUL_W'(pi_r); t2b = MUL_W'(pi_r);
      end
    endcase
  end

  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      OP_PH_M1: begin mul_a = MUL_W'(x_r);  mul_b = MUL_W'(sx_r); end
      OP_PH_M2: begin mul_a = MUL_W'(yw_r); mul_b = MUL_W'(sy_r); end
      OP_SQ_M0: begin mul_a = MUL_W'(arg_r); mul_b = MUL_W'(HALF_PI_Q30); end
      OP_SQ_M2: begin mul_a = MUL_W'(xq_r); mul_b = MUL_W'(xq_r); end
      OP_SQ_D1: begin mul_a = MUL_W'(x2_r); mul_b = MUL_W'(RECIP_42); end
      OP_SQ_D2: begin mul_a = MUL_W'(p_r[61:30]); mul_b = MUL_W'(RECIP_20); end
      OP_SQ_D3: begin mul_a = MUL_W'(p_r[61:30]); mul_b = MUL_W'(RECIP_6); end
      OP_SQ_M3,
      OP_SQ_M4: begin mul_a = MUL_W'(x2_r); mul_b = MUL_W'(tt_r); end
      OP_SQ_M5: begin mul_a = MUL_W'(xq_r); mul_b = MUL_W'(tt_r); end
      OP_R_M1:  begin mul_a = MUL_W'(cos_r); mul_b = MUL_W'(c_r); end
      OP_R_M2:  begin mul_a = MUL_W'(sin_r); mul_b = MUL_W'(d_r); end
      OP_R_M3: begin
        mul_a = MUL_W'(18'(cos_r) + 18'(sin_r));
        mul_b = MUL_W'(25'(c_r) + 25'(d_r));
      end
      OP_T_M1:  begin mul_a = t1a; mul_b = t1b; end
      OP_T_M2:  begin mul_a = t2a; mul_b = t2b; end
      OP_T_M4:  begin mul_a = term_r; mul_b = MUL_W'(dmg_r); end
      default:  mul_en = 1'b0;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd.op)
      OP_MOD_GO: begin
        div_num = DIV_NUM_W'(unsigned'(ph_abs));
        div_den = DIV_DEN_W'(den);
      end
      OP_IDX_GO: begin
        div_num = DIV_NUM_W'({r_r, {PB{1'b0}}}) + DIV_NUM_W'(den[24:1]);
        div_den = DIV_DEN_W'(den);
      end
      default: ;
    endcase
  end

  psfc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_num),
    .divisor   (div_den),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= BOX_RESET;
    end else if (cfg_we) begin
      box_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cross_acc_r <= '0;
      obs_acc_r   <= '0;
      pred_acc_r  <= '0;
    end else if (cmd.op == OP_T_ACC) begin
      case (cmd.sel)
        TERM_CROSS: cross_acc_r <= sat_add(cross_acc_r, p_r, 1'b0);
        TERM_OBS:   obs_acc_r   <= sat_add(obs_acc_r, p_r, 1'b1);
        default:    pred_acc_r  <= sat_add(pred_acc_r, p_r, 1'b1);
      endcase
    end else if (cmd.emit) begin
      cross_acc_r <= '0;
      obs_acc_r   <= '0;
      pred_acc_r  <= '0;
    end
  end

  assign obs64  = 64'(obs_acc_r);
  assign pred64 = 64'(pred_acc_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= item.freq_x;
      yw_r   <= y_wrap;
      sx_r   <= item.shift_x;
      sy_r   <= item.shift_y;
      c_r    <= samp(item.obs_real);
      d_r    <= samp(item.obs_imag);
      pr_r   <= samp(item.pred_real);
      pi_r   <= samp(item.pred_imag);
      dmg_r  <= item.damage_weight;
      last_r <= item.last_item;
    end
    if (mul_en) begin
      p_r <= prod;
    end
    if (cmd.emit) begin
      res_r.cross_sum   <= 64'(cross_acc_r);
      res_r.obs_energy  <= obs64[62:0];
      res_r.pred_energy <= pred64[62:0];
    end
    case (cmd.op)
      OP_PH_M2:   ph_r <= 39'(p_r);
      OP_PH_SUM:  ph_r <= ph_r + 39'(p_r);
      // Floor modulo: a negative phase sum folds back into [0, den).
      OP_MOD_FIX: r_r <= (ph_r[38] && (div_rem[24:0] != '0))
                         ? den - div_rem[24:0] : div_rem[24:0];
      OP_IDX_SET: idx_r <= div_quo[PB-1:0];
      OP_SQ_SEL: begin
        arg_r <= ang[PB-2] ? QUARTER_ARG - (PB-1)'(ang[PB-3:0])
                           : (PB-1)'(ang[PB-3:0]);
        neg_r <= ang[PB-1];
      end
      OP_SQ_XQ:   xq_r <= p_r[PB-2 +: 31];
      OP_SQ_X2:   x2_r <= p_r[61:30];
      OP_SQ_T1,
      OP_SQ_T2,
      OP_SQ_T3:   tt_r <= Q30_ONE - p_r[RECIP_SHIFT +: 31];
      OP_SQ_FIN: begin
        if (cmd.which) begin
          cos_r <= s_val;
        end else begin
          sin_r <= s_val;
        end
      end
      OP_R_M2:    ac_r <= 41'(p_r);
      OP_R_M3:    bd_r <= 41'(p_r);
      OP_R_Z: begin
        zr_r <= zr_full[40:15];
        zi_r <= zi_full[40:15];
      end
      OP_T_M2:    sum_r <= 54'(p_r);
      OP_T_M3:    term_r <= tsum[53:16];
      default: ;
    endcase
  end

  assign stat.div_busy = div_busy;
  assign stat.last     = last_r;
  assign res           = res_r;

endmodule
`default_nettype wire

// ----- rtl/psfc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psfc_ctrl
// Sequencer that steps the datapath through one pixel and owns the handshakes.
// ----------------------------------------------------------------------------
module psfc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  psfc_pkg::psfc_stat_t  stat,
  output psfc_pkg::psfc_cmd_t   cmd
);
  import psfc_pkg::*;

  psfc_state_t state_r, state_nxt;
  psfc_op_t    op_r, op_nxt;
  logic        which_r, which_nxt;
  psfc_term_t  sel_r, sel_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= OP_NONE;
      which_r     <= 1'b0;
      sel_r       <= TERM_CROSS;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      which_r     <= which_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    which_nxt     = which_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.which     = which_r;
    cmd.sel       = sel_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          op_nxt    = OP_PH_M1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.op = op_r;
        case (op_r)
          OP_PH_M1:   op_nxt = OP_PH_M2;
          OP_PH_M2:   op_nxt = OP_PH_SUM;
          OP_PH_SUM:  op_nxt = OP_MOD_GO;
          OP_MOD_GO: begin
            cmd.div_start = 1'b1;
            op_nxt        = OP_MOD_FIX;
            state_nxt     = ST_WAIT;
          end
          OP_MOD_FIX: op_nxt = OP_IDX_GO;
          OP_IDX_GO: begin
            cmd.div_start = 1'b1;
            op_nxt        = OP_IDX_SET;
            state_nxt     = ST_WAIT;
          end
          OP_IDX_SET: begin
            which_nxt = 1'b0;
            op_nxt    = OP_SQ_SEL;
          end
          OP_SQ_SEL:  op_nxt = OP_SQ_M0;
          OP_SQ_M0:   op_nxt = OP_SQ_XQ;
          OP_SQ_XQ:   op_nxt = OP_SQ_M2;
          OP_SQ_M2:   op_nxt = OP_SQ_X2;
          OP_SQ_X2:   op_nxt = OP_SQ_D1;
          OP_SQ_D1:   op_nxt = OP_SQ_T1;
          OP_SQ_T1:   op_nxt = OP_SQ_M3;
          OP_SQ_M3:   op_nxt = OP_SQ_D2;
          OP_SQ_D2:   op_nxt = OP_SQ_T2;
          OP_SQ_T2:   op_nxt = OP_SQ_M4;
          OP_SQ_M4:   op_nxt = OP_SQ_D3;
          OP_SQ_D3:   op_nxt = OP_SQ_T3;
          OP_SQ_T3:   op_nxt = OP_SQ_M5;
          OP_SQ_M5:   op_nxt = OP_SQ_FIN;
          // The sine is evaluated first, then the same steps run for the cosine.
          OP_SQ_FIN: begin
            if (!which_r) begin
              which_nxt = 1'b1;
              op_nxt    = OP_SQ_SEL;
            end else begin
              op_nxt = OP_R_M1;
            end
          end
          OP_R_M1:    op_nxt = OP_R_M2;
          OP_R_M2:    op_nxt = OP_R_M3;
          OP_R_M3:    op_nxt = OP_R_Z;
          OP_R_Z: begin
            sel_nxt = TERM_CROSS;
            op_nxt  = OP_T_M1;
          end
          OP_T_M1:    op_nxt = OP_T_M2;
          OP_T_M2:    op_nxt = OP_T_M3;
          OP_T_M3:    op_nxt = OP_T_M4;
          OP_T_M4:    op_nxt = OP_T_ACC;
          OP_T_ACC: begin
            if (sel_r == TERM_PRED) begin
              op_nxt    = OP_NONE;
              state_nxt = stat.last ? ST_EMIT : ST_IDLE;
            end else begin
              sel_nxt = (sel_r == TERM_CROSS) ? TERM_OBS : TERM_PRED;
              op_nxt  = OP_T_M1;
            end
          end
          default: begin
            op_nxt    = OP_NONE;
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = ST_RUN;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ----- dv/phase_shifted_fourier_correlation_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_shifted_fourier_correlation_tb
// Drives Fourier pixels with random gaps, predicts the three correlation sums
// in a bit-exact model of its own, and checks each emitted result in order.
// ----------------------------------------------------------------------------
module phase_shifted_fourier_correlation_tb;
  import psfc_pkg::*;

  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;
  localparam int PIXEL_CYCLES = 600;
  localparam longint CYCLE_LIMIT = 64'd5_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [BOX_W-1:0] cfg_wdata = '0;

  psfc_in_if in_ch ();
  psfc_out_if out_ch ();

  phase_shifted_fourier_correlation dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Model state.
  logic [BOX_W-1:0] box_model;
  longint cross_model, obs_model, pred_model;
  psfc_result_t sums_pending[$];

  int errors = 0;
  longint cycle_count = 0;
  bit calm = 1'b0;     // no idling in the closing part
  bit hold_off = 1'b0; // long receiver stall requested

  initial begin
    in_ch.valid = 1'b0;
    in_ch.freq_x = '0;
    in_ch.freq_y = '0;
    in_ch.shift_x = '0;
    in_ch.shift_y = '0;
    in_ch.obs_real = '0;
    in_ch.obs_imag = '0;
    in_ch.pred_real = '0;
    in_ch.pred_imag = '0;
    in_ch.damage_weight = '0;
    in_ch.last_item = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint floor_shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint quarter_sine(longint f);
    longint unsigned x, x2, t, s;
    x = (longint'(f) * 64'd1686629713) >> 14;
    x2 = (x * x) >> 30;
    t = (64'd1 << 30) - x2 / 42;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 20;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 6;
    s = (x * t) >> 30;
    s = (s + 16384) >> 15;
    if (s > 32767) s = 32767;
    return longint'(s);
  endfunction

  function automatic longint turn_sine(longint unsigned p);
    longint unsigned q, f;
    p = p & 64'hFFFF;
    q = p >> 14;
    f = p & 64'h3FFF;
    case (q)
      0: return quarter_sine(f);
      1: return quarter_sine(16384 - f);
      2: return -quarter_sine(f);
      default: return -quarter_sine(16384 - f);
    endcase
  endfunction

  function automatic longint sat_sum(longint acc, longint term, longint lo);
    if (term > 0 && acc > SUM_MAX - term) return SUM_MAX;
    if (term < 0 && acc < lo - term) return lo;
    return acc + term;
  endfunction

  task automatic accumulate_pixel(input psfc_item_t px);
    longint s, x, y, den, r, a, b, c, d, pr, pi, ac, bd, abcd, zr, zi, dmg;
    longint unsigned idx;
    psfc_result_t res;
    s = (box_model < 2) ? 2 : longint'(box_model);
    x = px.freq_x;
    y = px.freq_y;
    if (y >= s / 2 + 1) y -= s;
    den = s << 12;
    r = (x * longint'(px.shift_x) + y * longint'(px.shift_y)) % den;
    if (r < 0) r += den;
    idx = ((longint'(r) << 16) + den / 2) / den;
    b = turn_sine(idx);
    a = turn_sine(idx + 16384);
    c = px.obs_real;
    d = px.obs_imag;
    pr = px.pred_real;
    pi = px.pred_imag;
    dmg = px.damage_weight;
    ac = a * c;
    bd = b * d;
    abcd = (a + b) * (c + d);
    zr = floor_shr(ac - bd + 16384, 15);
    zi = floor_shr(abcd - ac - bd + 16384, 15);
    cross_model = sat_sum(cross_model, floor_shr(pr * zr + pi * zi, 16) * dmg, SUM_MIN);
    obs_model = sat_sum(obs_model, floor_shr(zr * zr + zi * zi, 16) * dmg, 0);
    pred_model = sat_sum(pred_model, floor_shr(pr * pr + pi * pi, 16) * dmg, 0);
    if (px.last_item) begin
      res.cross_sum = cross_model;
      res.obs_energy = obs_model[62:0];
      res.pred_energy = pred_model[62:0];
      sums_pending = {sums_pending, res};
      cross_model = 0;
      obs_model = 0;
      pred_model = 0;
    end
  endtask

  // Sends one pixel, with an optional random gap before it.
  task automatic send_pixel(input psfc_item_t px);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.freq_x <= px.freq_x;
    in_ch.freq_y <= px.freq_y;
    in_ch.shift_x <= px.shift_x;
    in_ch.shift_y <= px.shift_y;
    in_ch.obs_real <= px.obs_real;
    in_ch.obs_imag <= px.obs_imag;
    in_ch.pred_real <= px.pred_real;
    in_ch.pred_imag <= px.pred_imag;
    in_ch.damage_weight <= px.damage_weight;
    in_ch.last_item <= px.last_item;
    do @(posedge clk); while (!in_ch.ready);
    accumulate_pixel(px);
  endtask

  task automatic idle_inputs();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_box(input logic [BOX_W-1:0] value);
    idle_inputs();
    while (sums_pending.size() != 0) @(posedge clk);
    repeat (PIXEL_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    box_model = value;
  endtask

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'(int'($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic psfc_item_t rand_pixel(input bit last);
    psfc_item_t px;
    int s;
    s = (box_model < 2) ? 2 : box_model;
    px.freq_x = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(0, s / 2));
    px.freq_y = ($urandom_range(0, 9) == 0) ? 12'($urandom)
                                            : 12'($urandom_range(0, (s > 4096 ? 4096 : s) - 1));
    px.shift_x = rand_sample();
    px.shift_y = rand_sample();
    px.obs_real = rand_sample();
    px.obs_imag = rand_sample();
    px.pred_real = rand_sample();
    px.pred_imag = rand_sample();
    px.damage_weight = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom);
    px.last_item = last;
    return px;
  endfunction

  // Result checker with random stalls and an optional long hold-off.
  initial begin
    psfc_result_t want;
    int stall;
    @(posedge rst_n);
    forever begin
      stall = 0;
      if (hold_off) stall = 3000;
      else if (!calm && $urandom_range(0, 3) == 0) stall = $urandom_range(1, 15);
      out_ch.ready <= (stall == 0);
      if (stall != 0) begin
        repeat (stall) @(posedge clk);
        hold_off = 1'b0;
        out_ch.ready <= 1'b1;
      end
      do @(posedge clk); while (!out_ch.valid);
      if (sums_pending.size() == 0) begin
        $display("%0t: result with none expected: cross %0d", $time, out_ch.cross_sum);
        errors++;
      end else begin
        want = sums_pending.pop_front();
        if (out_ch.cross_sum !== want.cross_sum) begin
          $display("%0t: cross_sum expected %0d actual %0d", $time,
                   want.cross_sum, out_ch.cross_sum);
          errors++;
        end
        if (out_ch.obs_energy !== want.obs_energy) begin
          $display("%0t: obs_energy expected %0d actual %0d", $time,
                   want.obs_energy, out_ch.obs_energy);
          errors++;
        end
        if (out_ch.pred_energy !== want.pred_energy) begin
          $display("%0t: pred_energy expected %0d actual %0d", $time,
                   want.pred_energy, out_ch.pred_energy);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    psfc_item_t px;
    px.freq_x = 12'hFFF;
    px.freq_y = 12'hFFF;
    px.shift_x = 24'sh7FFFFF;
    px.shift_y = 24'sh800000;
    px.obs_real = 24'sh7FFFFF;
    px.obs_imag = 24'sh800000;
    px.pred_real = 24'sh800000;
    px.pred_imag = 24'sh7FFFFF;
    px.damage_weight = 16'hFFFF;
    px.last_item = 1'b1;
    send_pixel(px);
    px = '0;
    px.last_item = 1'b1;
    send_pixel(px);
    // Last row of positive frequency, then the first negative one.
    px = rand_pixel(1'b0);
    px.freq_y = 12'(box_model / 2);
    send_pixel(px);
    px.freq_y = 12'(box_model / 2 + 1);
    px.last_item = 1'b1;
    send_pixel(px);
  endtask

  // Full-scale pixels with alternating prediction signs give the largest terms.
  task automatic test_saturation();
    psfc_item_t px;
    for (int i = 0; i < 12; i++) begin
      px = rand_pixel(i == 11);
      px.obs_real = 24'sh7FFFFF;
      px.obs_imag = 24'sh7FFFFF;
      px.pred_real = (i % 2) ? 24'sh800000 : 24'sh7FFFFF;
      px.pred_imag = px.pred_real;
      px.shift_x = '0;
      px.shift_y = '0;
      px.damage_weight = 16'hFFFF;
      send_pixel(px);
    end
  endtask

  task automatic test_random_sets(input int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel($urandom_range(0, 5) == 0));
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_pixel(rand_pixel(1'b1));
  endtask

  initial begin
    box_model = BOX_RESET;
    cross_model = 0;
    obs_model = 0;
    pred_model = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_saturation();
    test_backpressure();
    test_random_sets(150);
    write_box(13'd0);
    test_extremes();
    test_random_sets(80);
    write_box(13'd4096);
    test_extremes();
    test_random_sets(150);
    write_box(13'h1FFF);
    test_random_sets(60);
    write_box(13'd3);
    test_random_sets(100);
    write_box(13'd100);
    test_random_sets(140);
    calm = 1'b1;
    test_random_sets(100);
    send_pixel(rand_pixel(1'b1));
    idle_inputs();
    while (sums_pending.size() != 0) @(posedge clk);
    repeat (PIXEL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
